// ===== rtl/psp_pkg.sv =====
package psp_pkg;

  localparam int unsigned CoordW    = 16;
  localparam int unsigned DistW     = 25;
  localparam int unsigned Len2W     = 33;
  localparam int unsigned MagW      = 34;
  localparam int unsigned SqW       = 2 * MagW;
  localparam int unsigned QuoW      = 51;
  localparam int unsigned RootW     = 26;
  localparam int unsigned FrontDepth = 6;
  localparam int unsigned DivDepth  = QuoW;
  localparam int unsigned SqrtDepth = RootW;
  localparam int unsigned BackDepth = DivDepth + SqrtDepth;
  localparam int unsigned PipeDepth = FrontDepth + BackDepth;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StOutside = 2'd1,
    StZero    = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
  } in_beat_t;

  typedef struct packed {
    logic [DistW-1:0] perp_distance;
    logic [DistW-1:0] along_distance;
    logic [1:0]       status;
  } out_beat_t;

endpackage

// ===== rtl/point_segment_projection.sv =====
// Channel | Handshake            | Payload
// in      | in_valid_i/in_ready_o   | in_data_i  (psp_pkg::in_beat_t)
// out     | out_valid_o/out_ready_i | out_data_o (psp_pkg::out_beat_t)
//
// One beat enters per cycle while the output is not stalled; each beat passes through:
// 6 front stages, 51 divider steps (one quotient bit each), 26 root steps.
// Reset clears only the valid bits; there is no clearing pass.
// A stalled output beat freezes the whole pipeline, in_ready_o drops with it.
module point_segment_projection (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  psp_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output psp_pkg::out_beat_t out_data_o
);
  import psp_pkg::*;

  logic             en;
  logic [PipeDepth-1:0] vld_q;
  status_e          st_q [BackDepth];
  status_e          front_st;
  logic [SqW-1:0]   sq_perp, sq_along;
  logic [Len2W-1:0] len2;
  logic [QuoW-1:0]  quo_perp, quo_along;
  logic [RootW-1:0] root_perp, root_along;

  assign en         = ~vld_q[PipeDepth-1] | out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeDepth-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= front_st;
      for (int i = 1; i < BackDepth; i++) begin
        st_q[i] <= st_q[i-1];
      end
    end
  end

  psp_front u_front (
    .clk_i      (clk_i),
    .en_i       (en),
    .data_i     (in_data_i),
    .sq_perp_o  (sq_perp),
    .sq_along_o (sq_along),
    .len2_o     (len2),
    .status_o   (front_st)
  );

  psp_div u_div_perp (
    .clk_i (clk_i),
    .en_i  (en),
    .sq_i  (sq_perp),
    .den_i (len2),
    .quo_o (quo_perp)
  );

  psp_div u_div_along (
    .clk_i (clk_i),
    .en_i  (en),
    .sq_i  (sq_along),
    .den_i (len2),
    .quo_o (quo_along)
  );

  psp_isqrt u_sqrt_perp (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (quo_perp),
    .root_o (root_perp)
  );

  psp_isqrt u_sqrt_along (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (quo_along),
    .root_o (root_along)
  );

  assign out_valid_o = vld_q[PipeDepth-1];
  always_comb begin
    out_data_o.status = st_q[BackDepth-1];
    if (st_q[BackDepth-1] == StOk) begin
      out_data_o.perp_distance  = root_perp[DistW-1:0];
      out_data_o.along_distance = root_along[DistW-1:0];
    end else begin
      out_data_o.perp_distance  = '0;
      out_data_o.along_distance = '0;
    end
  end

endmodule

// ===== rtl/psp_front.sv =====
module psp_front (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  psp_pkg::in_beat_t          data_i,
  output logic [psp_pkg::SqW-1:0]    sq_perp_o,
  output logic [psp_pkg::SqW-1:0]    sq_along_o,
  output logic [psp_pkg::Len2W-1:0]  len2_o,
  output psp_pkg::status_e           status_o
);
  import psp_pkg::*;

  logic signed [16:0] dx_q, dy_q, vx_q, vy_q;
  logic signed [33:0] p_vxdx_q, p_vydy_q, p_vxdy_q, p_vydx_q, p_dxdx_q, p_dydy_q;
  logic signed [34:0] dot_q, cross_q;
  logic [Len2W-1:0]   len2_s3_q, len2_s4_q, len2_s5_q, len2_s6_q;
  status_e            st_s4_q, st_s5_q, st_s6_q;
  status_e            st_d;
  logic [MagW-1:0]    acr_q, adot_q;
  logic [MagW-1:0]    acr_d;
  logic [33:0]        c_hh_q, c_hl_q, c_ll_q, d_hh_q, d_hl_q, d_ll_q;
  logic [SqW-1:0]     sq_perp_q, sq_along_q;
  logic signed [34:0] neg_cross;

  assign neg_cross = -cross_q;
  assign acr_d = cross_q[34] ? neg_cross[MagW-1:0] : cross_q[MagW-1:0];

  always_comb begin
    if (len2_s3_q == '0) begin
      st_d = StZero;
    end else if (dot_q[34] || (dot_q[33:0] > {1'b0, len2_s3_q})) begin
      st_d = StOutside;
    end else begin
      st_d = StOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // difference vectors
      dx_q <= $signed({data_i.end_x[15], data_i.end_x}) -
              $signed({data_i.start_x[15], data_i.start_x});
      dy_q <= $signed({data_i.end_y[15], data_i.end_y}) -
              $signed({data_i.start_y[15], data_i.start_y});
      vx_q <= $signed({data_i.point_x[15], data_i.point_x}) -
              $signed({data_i.start_x[15], data_i.start_x});
      vy_q <= $signed({data_i.point_y[15], data_i.point_y}) -
              $signed({data_i.start_y[15], data_i.start_y});
      // products
      p_vxdx_q <= vx_q * dx_q;
      p_vydy_q <= vy_q * dy_q;
      p_vxdy_q <= vx_q * dy_q;
      p_vydx_q <= vy_q * dx_q;
      p_dxdx_q <= dx_q * dx_q;
      p_dydy_q <= dy_q * dy_q;
      // sums
      dot_q     <= {p_vxdx_q[33], p_vxdx_q} + {p_vydy_q[33], p_vydy_q};
      cross_q   <= {p_vxdy_q[33], p_vxdy_q} - {p_vydx_q[33], p_vydx_q};
      len2_s3_q <= {1'b0, p_dxdx_q[31:0]} + {1'b0, p_dydy_q[31:0]};
      // classify, magnitudes
      st_s4_q   <= st_d;
      acr_q     <= acr_d;
      adot_q    <= dot_q[MagW-1:0];
      len2_s4_q <= len2_s3_q;
      // partial squares
      c_hh_q    <= acr_q[33:17] * acr_q[33:17];
      c_hl_q    <= acr_q[33:17] * acr_q[16:0];
      c_ll_q    <= acr_q[16:0] * acr_q[16:0];
      d_hh_q    <= adot_q[33:17] * adot_q[33:17];
      d_hl_q    <= adot_q[33:17] * adot_q[16:0];
      d_ll_q    <= adot_q[16:0] * adot_q[16:0];
      st_s5_q   <= st_s4_q;
      len2_s5_q <= len2_s4_q;
      // full squares
      sq_perp_q  <= {c_hh_q, 34'b0} + {16'b0, c_hl_q, 18'b0} + {34'b0, c_ll_q};
      sq_along_q <= {d_hh_q, 34'b0} + {16'b0, d_hl_q, 18'b0} + {34'b0, d_ll_q};
      st_s6_q    <= st_s5_q;
      len2_s6_q  <= len2_s5_q;
    end
  end

  assign sq_perp_o  = sq_perp_q;
  assign sq_along_o = sq_along_q;
  assign len2_o     = len2_s6_q;
  assign status_o   = st_s6_q;

endmodule

// ===== rtl/psp_div.sv =====
module psp_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [psp_pkg::SqW-1:0]    sq_i,
  input  logic [psp_pkg::Len2W-1:0]  den_i,
  output logic [psp_pkg::QuoW-1:0]   quo_o
);
  import psp_pkg::*;

  logic [Len2W-1:0] rem_q [DivDepth];
  logic [Len2W-1:0] den_q [DivDepth];
  logic [QuoW-1:0]  num_q [DivDepth];
  logic [QuoW-1:0]  quo_q [DivDepth];

  for (genvar g = 0; g < DivDepth; g++) begin : g_step
    logic [Len2W-1:0] rem_s, den_s;
    logic [QuoW-1:0]  num_s, quo_s;
    logic [Len2W:0]   t, diff;
    logic             ge;

    if (g == 0) begin : g_first
      assign rem_s = sq_i[SqW-1:SqW-Len2W];
      assign num_s = {sq_i[SqW-Len2W-1:0], 16'b0};
      assign quo_s = '0;
      assign den_s = den_i;
    end else begin : g_next
      assign rem_s = rem_q[g-1];
      assign num_s = num_q[g-1];
      assign quo_s = quo_q[g-1];
      assign den_s = den_q[g-1];
    end

    assign t    = {rem_s, num_s[QuoW-1]};
    assign ge   = t >= {1'b0, den_s};
    assign diff = t - {1'b0, den_s};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= ge ? diff[Len2W-1:0] : t[Len2W-1:0];
        num_q[g] <= {num_s[QuoW-2:0], 1'b0};
        quo_q[g] <= {quo_s[QuoW-2:0], ge};
        den_q[g] <= den_s;
      end
    end
  end

  assign quo_o = quo_q[DivDepth-1];

endmodule

// ===== rtl/psp_isqrt.sv =====
module psp_isqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [psp_pkg::QuoW-1:0]  rad_i,
  output logic [psp_pkg::RootW-1:0] root_o
);
  import psp_pkg::*;

  localparam int unsigned RadW = 2 * RootW;
  localparam int unsigned RemW = RootW + 2;

  logic [RadW-1:0]  rad_q  [SqrtDepth];
  logic [RootW-1:0] root_q [SqrtDepth];
  logic [RemW-1:0]  rem_q  [SqrtDepth];

  for (genvar g = 0; g < SqrtDepth; g++) begin : g_step
    logic [RadW-1:0]  rad_s;
    logic [RootW-1:0] root_s;
    logic [RemW-1:0]  rem_s;
    logic [RemW+1:0]  r2, trial, diff;
    logic             ge;

    if (g == 0) begin : g_first
      assign rad_s  = {{(RadW-QuoW){1'b0}}, rad_i};
      assign root_s = '0;
      assign rem_s  = '0;
    end else begin : g_next
      assign rad_s  = rad_q[g-1];
      assign root_s = root_q[g-1];
      assign rem_s  = rem_q[g-1];
    end

    assign r2    = {rem_s, rad_s[RadW-1:RadW-2]};
    assign trial = {2'b0, root_s, 2'b01};
    assign ge    = r2 >= trial;
    assign diff  = r2 - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[g]  <= {rad_s[RadW-3:0], 2'b00};
        root_q[g] <= {root_s[RootW-2:0], ge};
        rem_q[g]  <= ge ? diff[RemW-1:0] : r2[RemW-1:0];
      end
    end
  end

  assign root_o = root_q[SqrtDepth-1];

endmodule

// ===== rtl/psp_checker.sv =====
module psp_props (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input psp_pkg::in_beat_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input psp_pkg::out_beat_t out_data_o
);
  import psp_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat dropped or changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed under stall");

  a_stall_couple: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StOk) |->
      (out_data_o.perp_distance == '0) && (out_data_o.along_distance == '0))
    else $error("distances nonzero on a failed projection");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == StOk) || (out_data_o.status == StOutside) ||
      (out_data_o.status == StZero))
    else $error("undefined status code");

endmodule

bind point_segment_projection psp_props u_psp_props (.*);

// ===== verif/psp_checker.sv =====
module psp_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  psp_pkg::in_beat_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  psp_pkg::out_beat_t out_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  import psp_pkg::*;

  out_beat_t expected_q[$];

  function automatic logic [63:0] root_floor(logic [127:0] x);
    logic [63:0] r;
    int b;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      logic [63:0] t;
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  function automatic out_beat_t project(in_beat_t b);
    out_beat_t o;
    longint dx, dy, vx, vy, dot, crs, len2;
    logic [127:0] num;
    dx = longint'(b.end_x) - longint'(b.start_x);
    dy = longint'(b.end_y) - longint'(b.start_y);
    vx = longint'(b.point_x) - longint'(b.start_x);
    vy = longint'(b.point_y) - longint'(b.start_y);
    dot = vx * dx + vy * dy;
    crs = vx * dy - vy * dx;
    len2 = dx * dx + dy * dy;
    o = '0;
    if (len2 == 0) begin
      o.status = StZero;
    end else if (dot < 0 || dot > len2) begin
      o.status = StOutside;
    end else begin
      if (crs < 0) crs = -crs;
      num = (128'(crs) * 128'(crs) << 16) / 128'(len2);
      o.perp_distance = DistW'(root_floor(num));
      num = (128'(dot) * 128'(dot) << 16) / 128'(len2);
      o.along_distance = DistW'(root_floor(num));
      o.status = StOk;
    end
    return o;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_beat_t e;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_q.push_back(project(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat %p", $time, out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.perp_distance !== out_data_i.perp_distance ||
              e.along_distance !== out_data_i.along_distance ||
              e.status !== out_data_i.status) begin
            $display("%0t: expected %p actual %p", $time, e, out_data_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== verif/testbench.sv =====
module testbench;
  import psp_pkg::*;

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  in_beat_t in_data;
  out_beat_t out_data;
  int errors, pending, in_idle, out_idle, quiet;
  bit hold_out;

  point_segment_projection uut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  psp_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .in_data_i(in_data), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_data_i(out_data), .errors_o(errors), .pending_o(pending)
  );

  initial clk = 0;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) quiet <= 0;
    else if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("point_segment_projection regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_out) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= out_idle);
  end

  function automatic logic [15:0] pick();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    int m;
    b = {pick(), pick(), pick(), pick(), pick(), pick()};
    m = $urandom_range(9);
    if (m == 0) begin
      b.end_x = b.start_x;
      b.end_y = b.start_y;
    end else if (m < 6) begin
      b.point_x = 16'(($signed(17'(b.start_x)) + $signed(17'(b.end_x))) >>> 1);
      b.point_y = 16'(($signed(17'(b.start_y)) + $signed(17'(b.end_y))) >>> 1);
      b.point_x = b.point_x + 16'(int'($urandom_range(200)) - 100);
      b.point_y = b.point_y + 16'(int'($urandom_range(200)) - 100);
    end
    return b;
  endfunction

  task automatic send(in_beat_t b);
    if ($urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < in_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    in_beat_t d[$];
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    hold_out = 0;
    in_idle = 0;
    out_idle = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    d.push_back({16'sd5, 16'sd3, 16'sd0, 16'sd0, 16'sd10, 16'sd0});
    d.push_back({16'sd0, 16'sd7, 16'sd0, 16'sd0, 16'sd10, 16'sd0});
    d.push_back({16'sd10, 16'sd7, 16'sd0, 16'sd0, 16'sd10, 16'sd0});
    d.push_back({-16'sd1, 16'sd7, 16'sd0, 16'sd0, 16'sd10, 16'sd0});
    d.push_back({16'sd11, 16'sd7, 16'sd0, 16'sd0, 16'sd10, 16'sd0});
    d.push_back({16'sd4, 16'sd4, 16'sd3, 16'sd3, 16'sd3, 16'sd3});
    d.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    d.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
    d.push_back({16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
    d.push_back({16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
    d.push_back({16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
    d.push_back({16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd3, 16'sd1});
    d.push_back({16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'hffff});
    d.push_back({16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0001});
    foreach (d[i]) send(d[i]);
    in_idle = 14;
    out_idle = 66;
    repeat (600) send(rand_beat());
    in_valid <= 1'b0;
    drain();
    fork
      begin
        hold_out = 1;
        repeat (300) @(posedge clk);
        hold_out = 0;
      end
      begin
        repeat (150) send(rand_beat());
        in_valid <= 1'b0;
      end
    join
    drain();
    in_idle = 66;
    out_idle = 14;
    repeat (550) send(rand_beat());
    in_idle = 0;
    out_idle = 0;
    repeat (550) send(rand_beat());
    in_valid <= 1'b0;
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("point_segment_projection regression: pass");
    end else begin
      $display("point_segment_projection regression: fail");
    end
    $finish;
  end
endmodule
